FILE: rtl/pds_pkg.sv
`default_nettype none
package pds_pkg;

	localparam int TargetW  = 32;
	localparam int RefW     = 27;
	localparam int MultW    = 16;
	localparam int PdivW    = 4;
	localparam int DivW     = 6;
	localparam int CandCount = 24;
	localparam int CandIdxW = $clog2(CandCount);
	localparam int AddrW    = 4;
	localparam int DataW    = 32;

	localparam logic [RefW-1:0]  REF_RESET = RefW'(32768);
	localparam logic [MultW-1:0] MIN_RESET = '0;
	localparam logic [MultW-1:0] MAX_RESET = '1;

	// register indexes (word address)
	localparam logic [1:0] REG_REF   = 2'd0;
	localparam logic [1:0] REG_MIN   = 2'd1;
	localparam logic [1:0] REG_MAX   = 2'd2;
	localparam logic [1:0] REG_ORDER = 2'd3;

	typedef struct packed {
		logic [DivW-1:0]  div;
		logic             halve;
		logic [PdivW-1:0] pdiv;
	} cand_t;

	// candidate divider for a given search order and position
	function automatic cand_t cand_entry(input logic order, input logic [CandIdxW-1:0] idx);
		cand_t c;
		logic [DivW-1:0] i6;
		logic [DivW-1:0] half_m1;
		logic [DivW-1:0] d_m1;
		i6 = {1'b0, idx};
		if (!order) begin
			if (idx < CandIdxW'(15)) begin
				c.div   = i6 + 6'd1;
				c.halve = 1'b0;
			end else begin
				c.div   = (i6 << 1) - 6'd14;
				c.halve = 1'b1;
			end
		end else begin
			if (idx < CandIdxW'(8)) begin
				c.div   = 6'd32 - (i6 << 1);
				c.halve = 1'b1;
			end else begin
				c.div   = 6'd24 - i6;
				c.halve = 1'b0;
			end
		end
		half_m1 = (c.div >> 1) - 6'd1;
		d_m1    = c.div - 6'd1;
		c.pdiv  = c.halve ? half_m1[PdivW-1:0] : d_m1[PdivW-1:0];
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/pll_divider_setting_search.sv
// pll divider setting search
//
// input channel: in_valid / in_stall carry target_hz, one transaction per request.
// output channel: out_valid / out_stall carry found, multiplier, post_divider,
// vco_halve and achieved_hz, exactly one transaction per input transaction.
// configuration: apb-style port, ref_clock_hz at 0x0, min_multiplier at 0x4,
// max_multiplier at 0x8, search_order at 0xc; pready is tied high.
// the request is registered, then the 32-bit target goes through restoring
// division (one quotient bit per cycle through the shared subtractor), then one
// candidate divider is checked per cycle until a hit or the last of the 24.
// a new request is taken only while the sequencer is idle, so the block
// cannot take a new request before it is through with the last search.
// the output register is separate from the sequencer: a new request may be
// taken while the last result still waits. if the receiver stalls when a
// search completes, the sequencer holds its last candidate until the
// output register frees up.
// reset (arst_n low) returns the registers to their defaults, empties the
// output register and puts the sequencer in idle.
`default_nettype none
module pll_divider_setting_search (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// request channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [pds_pkg::TargetW-1:0] target_hz,
	// result channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            found,
	output logic [pds_pkg::MultW-1:0]       multiplier,
	output logic [pds_pkg::PdivW-1:0]       post_divider,
	output logic                            vco_halve,
	output logic [pds_pkg::TargetW-1:0]     achieved_hz,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pds_pkg::AddrW-1:0]  paddr,
	input  wire logic [pds_pkg::DataW-1:0]  pwdata,
	output logic [pds_pkg::DataW-1:0]       prdata,
	output logic                            pready
);
	import pds_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;

	localparam int ProdW = TargetW + DivW;

	// configuration registers
	logic [RefW-1:0]  ref_q;
	logic [MultW-1:0] min_q;
	logic [MultW-1:0] max_q;
	logic             order_q;

	// sequencer and datapath
	logic [1:0]          state_q;
	logic [4:0]          bit_cnt_q;
	logic [CandIdxW-1:0] idx_q;
	logic [TargetW-1:0]  target_q;
	logic [TargetW-1:0]  quo_q;   // dividend shifts out, quotient shifts in
	logic [RefW-1:0]     rem_q;

	// output register
	logic                out_valid_q;
	logic                found_q;
	logic [MultW-1:0]    mult_q;
	logic [PdivW-1:0]    pdiv_q;
	logic                halve_q;
	logic [TargetW-1:0]  ach_q;

	logic                cfg_wr;
	logic                in_take;
	logic                out_free;
	logic [RefW:0]       trial;
	logic                trial_ok;
	cand_t               cand;
	logic [ProdW-1:0]    prod;
	logic                hit;
	logic                last_cand;
	logic [TargetW-1:0]  achieved;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// shared subtract unit for the restoring divide
	assign trial    = {rem_q, quo_q[TargetW-1]} - {1'b0, ref_q};
	assign trial_ok = !trial[RefW];

	// candidate check: q times a small divider, then the two bounds
	assign cand      = cand_entry(order_q, idx_q);
	assign prod      = {{DivW{1'b0}}, quo_q} * {{TargetW{1'b0}}, cand.div};
	assign hit       = (ref_q != '0) && (prod > ProdW'(min_q)) && (prod < ProdW'(max_q));
	assign last_cand = hit || (idx_q == CandIdxW'(CandCount - 1));
	// mult*ref/d reduces to q*ref, which is the dividend minus the remainder
	assign achieved  = target_q - TargetW'(rem_q);

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_REF:   prdata = DataW'(ref_q);
			REG_MIN:   prdata = DataW'(min_q);
			REG_MAX:   prdata = DataW'(max_q);
			REG_ORDER: prdata = DataW'(order_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= REF_RESET;
			min_q   <= MIN_RESET;
			max_q   <= MAX_RESET;
			order_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_REF:   ref_q   <= pwdata[RefW-1:0];
				REG_MIN:   min_q   <= pwdata[MultW-1:0];
				REG_MAX:   max_q   <= pwdata[MultW-1:0];
				REG_ORDER: order_q <= pwdata[0];
				default:   ;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q   <= ST_DIV;
						bit_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + 5'd1;
					if (bit_cnt_q == 5'd31) begin
						state_q <= ST_SRCH;
						idx_q   <= '0;
					end
				end
				ST_SRCH: begin
					if (last_cand && out_free) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else if (!last_cand) begin
						idx_q <= idx_q + CandIdxW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			target_q <= target_hz;
			quo_q    <= target_hz;
			rem_q    <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[TargetW-2:0], trial_ok};
			rem_q <= trial_ok ? trial[RefW-1:0] : {rem_q[RefW-2:0], quo_q[TargetW-1]};
		end
		if (state_q == ST_SRCH && last_cand && out_free) begin
			found_q <= hit;
			mult_q  <= hit ? prod[MultW-1:0] : '0;
			pdiv_q  <= hit ? cand.pdiv : '0;
			halve_q <= hit && cand.halve;
			ach_q   <= hit ? achieved : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign multiplier   = mult_q;
	assign post_divider = pdiv_q;
	assign vco_halve    = halve_q;
	assign achieved_hz  = ach_q;

	// a result only appears at the end of a search
	a_result_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_SRCH))
		else $error("result appeared outside the search phase");

	// a miss reports all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (multiplier == '0 && post_divider == '0 &&
			!vco_halve && achieved_hz == '0))
		else $error("miss with nonzero fields");

	// a hit respects the exclusive multiplier bounds
	a_hit_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (multiplier > min_q && multiplier < max_q))
		else $error("multiplier outside bounds");

	// once a request is taken, the request channel is held off and the division starts
	a_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (in_stall && state_q == ST_DIV))
		else $error("sequencer did not start the division");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import pds_pkg::*;

	// settle time that covers any search still running
	localparam int SETTLE_CYCLES = 80;
	// cycles without any transaction before the run is declared hung
	localparam int STUCK_LIMIT = 4000;

	// one expected divider setting, fields in port order
	typedef struct packed {
		logic               found;
		logic [MultW-1:0]   mult;
		logic [PdivW-1:0]   pdiv;
		logic               halve;
		logic [TargetW-1:0] freq;
	} pll_setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [TargetW-1:0] target_hz = '0;

	// result channel
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               found;
	logic [MultW-1:0]   multiplier;
	logic [PdivW-1:0]   post_divider;
	logic               vco_halve;
	logic [TargetW-1:0] achieved_hz;

	// configuration port
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	// local copy of the configuration registers
	logic [RefW-1:0]  ref_hz = REF_RESET;
	logic [MultW-1:0] min_mult = MIN_RESET;
	logic [MultW-1:0] max_mult = MAX_RESET;
	logic             search_desc = 1'b0;

	logic [TargetW-1:0] pending_targets[$];
	pll_setting_t       expected_settings[$];
	int                 open_requests = 0;
	int                 mismatch_count = 0;
	int                 stuck_cycles = 0;

	// sender burst shaping
	logic req_taken = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;

	// receiver stall pattern
	int stall_mode = 0;
	int stall_span = 0;

	pll_divider_setting_search uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_hz    (target_hz),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.multiplier   (multiplier),
		.post_divider (post_divider),
		.vco_halve    (vco_halve),
		.achieved_hz  (achieved_hz),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// divider search as the block should do it: ascending order walks d = 1..16 then
	// even d up to 32, descending walks even d from 32 down to 18 then 16..1;
	// d = 16 is halved only in ascending order
	function automatic pll_setting_t predict_setting(input logic [TargetW-1:0] tgt);
		pll_setting_t res;
		longint unsigned ratio;
		longint unsigned mult;
		longint unsigned freq;
		int unsigned div;
		int unsigned pdiv;
		logic halve;
		res = '0;
		// zero reference gives ratio 0, which never clears the lower bound
		ratio = (ref_hz != '0) ? {32'd0, tgt} / {37'd0, ref_hz} : 64'd0;
		for (int step = 0; step < 32; step++) begin
			div = search_desc ? 32 - step : step + 1;
			if (!res.found && (div <= 16 || div % 2 == 0)) begin
				halve = search_desc ? (div > 16) : (div >= 16);
				// exact 64-bit product, no wrap before the bound check
				mult = ratio * div;
				if (mult > min_mult && mult < max_mult) begin
					pdiv = halve ? div / 2 - 1 : div - 1;
					freq = mult * ref_hz / (pdiv + 1) / (halve + 1);
					if (freq > 64'hFFFF_FFFF)
						freq = 64'hFFFF_FFFF;
					res.found = 1'b1;
					res.mult  = mult[MultW-1:0];
					res.pdiv  = pdiv[PdivW-1:0];
					res.halve = halve;
					res.freq  = freq[TargetW-1:0];
				end
			end
		end
		return res;
	endfunction

	// random target, mostly aimed so that some divider lands inside the window
	function automatic logic [TargetW-1:0] pick_target();
		int unsigned kind;
		int unsigned lo;
		int unsigned hi;
		int unsigned m;
		int unsigned div;
		longint unsigned t;
		kind = $urandom_range(0, 9);
		lo = min_mult + 1;
		hi = max_mult - 1;
		if (ref_hz == '0 || kind < 2 || max_mult < 2 || lo > hi)
			return $urandom;
		div = $urandom_range(1, 32);
		if (kind == 2) begin
			// multiplier right on or next to a bound
			case ($urandom_range(0, 3))
				0: m = 32'(min_mult);
				1: m = lo;
				2: m = hi;
				default: m = 32'(max_mult);
			endcase
		end else begin
			m = $urandom_range(lo, hi);
		end
		t = longint'(m / div) * ref_hz + $urandom_range(0, ref_hz - 1);
		if (t > 64'hFFFF_FFFF)
			return $urandom;
		return t[TargetW-1:0];
	endfunction

	// driver: new request only once the last one went through
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_targets.size() != 0) begin
				in_valid <= 1'b1;
				target_hz <= pending_targets.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 8);
					// a quarter of the bursts run straight into the next one
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall mode is redrawn whenever its random span runs out
	always @(negedge clk) begin
		if (stall_span <= 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(20, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= stall_span[4];
		endcase
	end

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
			mismatch_count++;
		end
	endtask

	// monitor: predict on request transactions, check on result transactions
	always @(posedge clk) begin
		pll_setting_t exp_set;
		req_taken <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_settings.size() == 0) begin
				$display("%0t: result transaction with none expected, multiplier %0d",
					$realtime, multiplier);
				mismatch_count++;
			end else begin
				exp_set = expected_settings.pop_front();
				open_requests--;
				compare_field("found", 64'(exp_set.found), 64'(found));
				compare_field("multiplier", 64'(exp_set.mult), 64'(multiplier));
				compare_field("post_divider", 64'(exp_set.pdiv), 64'(post_divider));
				compare_field("vco_halve", 64'(exp_set.halve), 64'(vco_halve));
				compare_field("achieved_hz", 64'(exp_set.freq), 64'(achieved_hz));
			end
		end
		if (arst_n && in_valid && !in_stall)
			expected_settings.push_back(predict_setting(target_hz));
		// watchdog on any transaction, configuration accesses included
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, STUCK_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic check_register(input logic [1:0] idx, input logic [DataW-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d read expected %0h got %0h", $realtime, idx, want, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [DataW-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REF: ref_hz = value[RefW-1:0];
			REG_MIN: min_mult = value[MultW-1:0];
			REG_MAX: max_mult = value[MultW-1:0];
			default: search_desc = value[0];
		endcase
		case (idx)
			REG_REF: check_register(idx, DataW'(ref_hz));
			REG_MIN: check_register(idx, DataW'(min_mult));
			REG_MAX: check_register(idx, DataW'(max_mult));
			default: check_register(idx, DataW'(search_desc));
		endcase
	endtask

	task automatic queue_target(input logic [TargetW-1:0] tgt);
		pending_targets.push_back(tgt);
		open_requests++;
	endtask

	// sender holds off until every result is back, then the search engine settles
	task automatic drain();
		while (open_requests != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [DataW-1:0] ref_val, input logic [DataW-1:0] min_val,
			input logic [DataW-1:0] max_val, input logic order_val, input int count);
		write_register(REG_REF, ref_val);
		write_register(REG_MIN, min_val);
		write_register(REG_MAX, max_val);
		write_register(REG_ORDER, DataW'(order_val));
		for (int n = 0; n < count; n++)
			queue_target(pick_target());
		drain();
	endtask

	initial begin
		logic [DataW-1:0] rnd_ref;
		logic [DataW-1:0] rnd_min;
		logic [DataW-1:0] rnd_max;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset values of the registers
		check_register(REG_REF, DataW'(REF_RESET));
		check_register(REG_MIN, DataW'(MIN_RESET));
		check_register(REG_MAX, DataW'(MAX_RESET));
		check_register(REG_ORDER, '0);

		// directed targets at reset config: ratio 0, exact ratio 1, top of the
		// multiplier window, just past it, all-ones and bit patterns
		queue_target(32'd0);
		queue_target(32'd1);
		queue_target(32'd32767);
		queue_target(32'd32768);
		queue_target(32'd32769);
		queue_target(32'd65534 * 32'd32768);
		queue_target(32'd65535 * 32'd32768);
		queue_target(32'hFFFF_FFFF);
		queue_target(32'h8000_0000);
		queue_target(32'h7FFF_FFFF);
		queue_target(32'h5555_5555);
		queue_target(32'hAAAA_AAAA);
		drain();

		// extreme settings: smallest and largest reference, zero reference,
		// inverted window, a window that rejects everything, tight windows
		run_phase(64, 0, 65535, 1'b1, 40);
		run_phase(32'h07FF_FFFF, 0, 65535, 1'b0, 40);
		run_phase(100000000, 65535, 0, 1'b0, 20);
		run_phase(0, 0, 65535, 1'b1, 20);
		run_phase(1000, 65535, 65535, 1'b1, 20);
		run_phase(1000, 100, 200, 1'b1, 40);
		run_phase(250, 0, 1, 1'b0, 20);
		run_phase(5000, 3000, 4000, 1'b0, 40);

		// random settings
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 9))
				0: rnd_ref = 0;
				1, 2, 3: rnd_ref = $urandom_range(64, 100000);
				4, 5, 6: rnd_ref = $urandom_range(100000, 100000000);
				7: rnd_ref = 32'h07FF_FFFF;
				default: rnd_ref = $urandom_range(64, 5000);
			endcase
			rnd_min = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000);
			case ($urandom_range(0, 5))
				0: rnd_max = 65535;
				1: rnd_max = $urandom_range(0, 65535);
				default: rnd_max = $urandom_range(rnd_min, 65535);
			endcase
			run_phase(rnd_ref, rnd_min, rnd_max, 1'($urandom_range(0, 1)), 100);
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
